[hdl/lbct_pkg.sv]
`default_nettype none
package lbct_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int RANK_W  = $clog2(ENTRIES);
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int ADDR_W  = 32;
	localparam int CTR_W   = 32;
	localparam int SLOT_W  = 4;
	localparam int CFG_W   = 5;
	localparam int LIM_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	// Carried from cell to cell during the search cycle.
	typedef struct packed {
		logic              found;
		logic [IDX_W-1:0]  hit_slot;
		logic [RANK_W-1:0] hit_rank;
		logic [ADDR_W-1:0] vic_tag;
		logic [IDX_W-1:0]  vic_slot;
	} lbct_chain_t;

	// Broadcast to all cells during the update cycle.
	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  slot;
		logic              write_tag;
		logic [ADDR_W-1:0] tag;
		logic              age_all;
		logic [RANK_W-1:0] old_rank;
	} lbct_upd_t;

endpackage
`default_nettype wire

[hdl/lru_block_cache_tags_top.sv]
`default_nettype none
// Fully associative LRU tag store for a block cache.
// Input channel: opcode (0 read, 1 write) and block_address, taken when
// in_valid is high and in_stall is low. Output channel: one word per access
// with status, hit, slot, replaced, victim_address and the four hit/miss
// counters, taken when out_valid is high and out_stall is low.
// Config channel: active_entries, written when cfg_valid and cfg_ready are high;
// write it only while no access is in flight.
// Flow: an accepted word passes a search state, which registers the result of
// the cell-row search, and then an update state, which registers the output
// word; a new word is taken when idle or in the update step. The search ripples
// through the row of entry cells; the update is broadcast to all cells at once.
// While out_stall holds a finished result, the update step waits and
// in_stall stays high; nothing is lost.
// Reset: no entries filled, counters zero, active_entries 16, output empty.
// Zero addresses report status 1 and leave all state untouched.
module lru_block_cache_tags_top (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_valid,
	output logic                       in_stall,
	input  wire                        opcode,
	input  wire [lbct_pkg::ADDR_W-1:0] block_address,
	output logic                       out_valid,
	input  wire                        out_stall,
	output logic                       status,
	output logic                       hit,
	output logic [lbct_pkg::SLOT_W-1:0] slot,
	output logic                       replaced,
	output logic [lbct_pkg::ADDR_W-1:0] victim_address,
	output logic [lbct_pkg::CTR_W-1:0] read_hits,
	output logic [lbct_pkg::CTR_W-1:0] read_misses,
	output logic [lbct_pkg::CTR_W-1:0] write_hits,
	output logic [lbct_pkg::CTR_W-1:0] write_misses,
	input  wire                        cfg_valid,
	output logic                       cfg_ready,
	input  wire [lbct_pkg::CFG_W-1:0]  active_entries
);
	import lbct_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;
	localparam logic [1:0] ST_UPDATE = 2'd2;

	logic [1:0]        state_q;
	logic [CFG_W-1:0]  active_q;
	logic [CNT_W-1:0]  filled_q;
	logic [CTR_W-1:0]  rd_hit_q, rd_miss_q, wr_hit_q, wr_miss_q;

	logic              op_q;
	logic [ADDR_W-1:0] addr_q;

	// search results
	logic              hit_q;
	logic [IDX_W-1:0]  hit_slot_q;
	logic [RANK_W-1:0] hit_rank_q;
	logic [ADDR_W-1:0] vic_tag_q;
	logic [IDX_W-1:0]  vic_slot_q;

	logic              out_valid_q;
	logic              status_q, hit_o_q, replaced_q;
	logic [SLOT_W-1:0] slot_q;
	logic [ADDR_W-1:0] victim_q;

	lbct_chain_t       chain [ENTRIES+1];
	lbct_upd_t         upd;
	logic [RANK_W-1:0] last_rank;
	logic              can_load, in_take, do_update;
	logic              zero_addr, fill_ok;
	logic [LIM_W-1:0]  lim;
	logic [IDX_W-1:0]  new_slot;

	assign cfg_ready = 1'b1;
	assign can_load  = !out_valid_q || !out_stall;
	assign do_update = (state_q == ST_UPDATE) && can_load;
	assign in_stall  = !((state_q == ST_IDLE) || do_update);
	assign in_take   = in_valid && !in_stall;
	assign last_rank = RANK_W'(filled_q - 1'b1);
	assign zero_addr = (addr_q == '0);

	always_comb begin
		if (active_q == '0) begin
			lim = LIM_W'(1);
		end else if (LIM_W'(active_q) > LIM_W'(ENTRIES)) begin
			lim = LIM_W'(ENTRIES);
		end else begin
			lim = LIM_W'(active_q);
		end
	end

	assign fill_ok  = LIM_W'(filled_q) < lim;
	assign new_slot = hit_q ? hit_slot_q : (fill_ok ? IDX_W'(filled_q) : vic_slot_q);

	always_comb begin
		upd.en        = do_update && !zero_addr;
		upd.slot      = new_slot;
		upd.write_tag = !hit_q;
		upd.tag       = addr_q;
		upd.age_all   = !hit_q;
		upd.old_rank  = hit_rank_q;
	end

	assign chain[0] = '0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		lbct_cell u_cell (
			.clk       (clk),
			.idx       (IDX_W'(i)),
			.filled    (CNT_W'(i) < filled_q),
			.addr      (addr_q),
			.last_rank (last_rank),
			.chain_in  (chain[i]),
			.chain_out (chain[i+1]),
			.upd       (upd)
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			active_q  <= CFG_W'(16);
			filled_q  <= '0;
			rd_hit_q  <= '0;
			rd_miss_q <= '0;
			wr_hit_q  <= '0;
			wr_miss_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				active_q <= active_entries;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					if (do_update) begin
						state_q <= in_take ? ST_SEARCH : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (do_update) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (do_update && !zero_addr) begin
				if (!hit_q && fill_ok) begin
					filled_q <= filled_q + 1'b1;
				end
				unique case ({op_q, hit_q})
					2'b00: rd_miss_q <= rd_miss_q + 1'b1;
					2'b01: rd_hit_q  <= rd_hit_q + 1'b1;
					2'b10: wr_miss_q <= wr_miss_q + 1'b1;
					2'b11: wr_hit_q  <= wr_hit_q + 1'b1;
					default: ;
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			op_q   <= opcode;
			addr_q <= block_address;
		end
		if (state_q == ST_SEARCH) begin
			hit_q      <= chain[ENTRIES].found;
			hit_slot_q <= chain[ENTRIES].hit_slot;
			hit_rank_q <= chain[ENTRIES].hit_rank;
			vic_tag_q  <= chain[ENTRIES].vic_tag;
			vic_slot_q <= chain[ENTRIES].vic_slot;
		end
		if (do_update) begin
			if (zero_addr) begin
				status_q   <= 1'b1;
				hit_o_q    <= 1'b0;
				slot_q     <= '0;
				replaced_q <= 1'b0;
				victim_q   <= '0;
			end else begin
				status_q   <= 1'b0;
				hit_o_q    <= hit_q;
				slot_q     <= SLOT_W'(new_slot);
				replaced_q <= !hit_q && !fill_ok;
				victim_q   <= (!hit_q && !fill_ok) ? vic_tag_q : '0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign hit            = hit_o_q;
	assign slot           = slot_q;
	assign replaced       = replaced_q;
	assign victim_address = victim_q;
	// counters already hold the post-access values while the word waits
	assign read_hits      = rd_hit_q;
	assign read_misses    = rd_miss_q;
	assign write_hits     = wr_hit_q;
	assign write_misses   = wr_miss_q;

endmodule
`default_nettype wire

[hdl/lbct_cell.sv]
`default_nettype none
module lbct_cell (
	input  wire                        clk,
	input  wire [lbct_pkg::IDX_W-1:0]  idx,
	input  wire                        filled,
	input  wire [lbct_pkg::ADDR_W-1:0] addr,
	input  wire [lbct_pkg::RANK_W-1:0] last_rank,
	input  lbct_pkg::lbct_chain_t      chain_in,
	output lbct_pkg::lbct_chain_t      chain_out,
	input  lbct_pkg::lbct_upd_t        upd
);
	import lbct_pkg::*;

	logic [ADDR_W-1:0] tag_q;
	logic [RANK_W-1:0] rank_q;
	logic              match;
	logic              is_last;

	assign match   = filled && (tag_q == addr);
	assign is_last = filled && (rank_q == last_rank);

	// first match wins; the oldest entry is unique among filled ones
	always_comb begin
		chain_out = chain_in;
		if (!chain_in.found && match) begin
			chain_out.found    = 1'b1;
			chain_out.hit_slot = idx;
			chain_out.hit_rank = rank_q;
		end
		if (is_last) begin
			chain_out.vic_tag  = tag_q;
			chain_out.vic_slot = idx;
		end
	end

	always_ff @(posedge clk) begin
		if (upd.en) begin
			if (upd.slot == idx) begin
				rank_q <= '0;
				if (upd.write_tag) begin
					tag_q <= upd.tag;
				end
			end else if (filled && (upd.age_all || rank_q < upd.old_rank)) begin
				rank_q <= rank_q + 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench;
	import lbct_pkg::*;

	localparam int STALL_PCT    = 22;
	localparam int LONG_HOLD    = 300;
	localparam int WATCHDOG_MAX = 5000;
	localparam int POOL_SIZE    = 24;

	typedef struct packed {
		logic              op;
		logic [ADDR_W-1:0] addr;
	} access_t;

	typedef struct packed {
		logic              status;
		logic              hit;
		logic [SLOT_W-1:0] slot;
		logic              replaced;
		logic [ADDR_W-1:0] victim;
		logic [CTR_W-1:0]  rd_hit;
		logic [CTR_W-1:0]  rd_miss;
		logic [CTR_W-1:0]  wr_hit;
		logic [CTR_W-1:0]  wr_miss;
	} lookup_res_t;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                opcode = OP_READ;
	logic [ADDR_W-1:0]   block_address = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                status;
	logic                hit;
	logic [SLOT_W-1:0]   slot;
	logic                replaced;
	logic [ADDR_W-1:0]   victim_address;
	logic [CTR_W-1:0]    read_hits;
	logic [CTR_W-1:0]    read_misses;
	logic [CTR_W-1:0]    write_hits;
	logic [CTR_W-1:0]    write_misses;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CFG_W-1:0]    active_entries = '0;

	lru_block_cache_tags_top i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.block_address  (block_address),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.hit            (hit),
		.slot           (slot),
		.replaced       (replaced),
		.victim_address (victim_address),
		.read_hits      (read_hits),
		.read_misses    (read_misses),
		.write_hits     (write_hits),
		.write_misses   (write_misses),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.active_entries (active_entries)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow tag store
	logic [ADDR_W-1:0] tags [ENTRIES];
	int                ranks [ENTRIES];
	int                filled = 0;
	logic [CTR_W-1:0]  rd_hit_cnt = '0;
	logic [CTR_W-1:0]  rd_miss_cnt = '0;
	logic [CTR_W-1:0]  wr_hit_cnt = '0;
	logic [CTR_W-1:0]  wr_miss_cnt = '0;
	logic [CFG_W-1:0]  fill_cfg = CFG_W'(16);

	access_t           pending_accesses[$];
	lookup_res_t       expected_lookups[$];
	logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
	int                errors = 0;
	logic              quiet = 1'b0;
	logic              long_hold = 1'b0;

	task automatic make_youngest(input int idx, input int old_rank);
		int i;
		for (i = 0; i < filled; i++)
			if (i != idx && ranks[i] < old_rank)
				ranks[i]++;
		ranks[idx] = 0;
	endtask

	task automatic predict_lookup(input logic op, input logic [ADDR_W-1:0] addr,
			output lookup_res_t r);
		int i;
		int found_at;
		int lim;
		int oldest;
		int vic;
		r = '0;
		if (addr == '0) begin
			r.status = 1'b1;
		end else begin
			found_at = -1;
			for (i = 0; i < filled; i++)
				if (found_at < 0 && tags[i] == addr)
					found_at = i;
			if (found_at >= 0) begin
				r.hit = 1'b1;
				r.slot = SLOT_W'(found_at);
				make_youngest(found_at, ranks[found_at]);
				if (op == OP_WRITE)
					wr_hit_cnt++;
				else
					rd_hit_cnt++;
			end else begin
				if (op == OP_WRITE)
					wr_miss_cnt++;
				else
					rd_miss_cnt++;
				lim = (fill_cfg == 0) ? 1 : (int'(fill_cfg) > ENTRIES) ? ENTRIES : int'(fill_cfg);
				if (filled < lim) begin
					r.slot = SLOT_W'(filled);
					tags[filled] = addr;
					filled++;
					make_youngest(filled - 1, ENTRIES + 1);
				end else begin
					// last entry holding the highest rank goes
					oldest = 0;
					vic = 0;
					for (i = 0; i < filled; i++)
						if (ranks[i] >= oldest) begin
							oldest = ranks[i];
							vic = i;
						end
					r.slot = SLOT_W'(vic);
					r.replaced = 1'b1;
					r.victim = tags[vic];
					tags[vic] = addr;
					make_youngest(vic, oldest);
				end
			end
		end
		r.rd_hit = rd_hit_cnt;
		r.rd_miss = rd_miss_cnt;
		r.wr_hit = wr_hit_cnt;
		r.wr_miss = wr_miss_cnt;
	endtask

	task automatic check_field(input string nm, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, nm, want, got);
		end
	endtask

	// driver
	always @(posedge clk) begin : drive
		access_t w;
		if (arst_n) begin
			if (!in_valid || !in_stall) begin
				if (pending_accesses.size() != 0 &&
						(quiet || $urandom_range(0, 99) >= STALL_PCT)) begin
					w = pending_accesses.pop_front();
					in_valid <= 1'b1;
					opcode <= w.op;
					block_address <= w.addr;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall, with one long hold-off on request
	int   hold_left = 0;
	logic hold_seen = 1'b0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (long_hold && !hold_seen) begin
				hold_seen <= 1'b1;
				hold_left <= LONG_HOLD;
				out_stall <= 1'b1;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !quiet && ($urandom_range(0, 99) < STALL_PCT);
			end
		end
	end

	// monitor: check results, then predict newly taken words
	always @(posedge clk) begin : monitor
		lookup_res_t got;
		lookup_res_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = '{status, hit, slot, replaced, victim_address,
					read_hits, read_misses, write_hits, write_misses};
				if (expected_lookups.size() == 0) begin
					errors++;
					$display("%0t: unexpected result word, expected none, actual %h",
						$time, got);
				end else begin
					want = expected_lookups.pop_front();
					check_field("status", 32'(want.status), 32'(got.status));
					check_field("hit", 32'(want.hit), 32'(got.hit));
					check_field("slot", 32'(want.slot), 32'(got.slot));
					check_field("replaced", 32'(want.replaced), 32'(got.replaced));
					check_field("victim_address", want.victim, got.victim);
					check_field("read_hits", want.rd_hit, got.rd_hit);
					check_field("read_misses", want.rd_miss, got.rd_miss);
					check_field("write_hits", want.wr_hit, got.wr_hit);
					check_field("write_misses", want.wr_miss, got.wr_miss);
				end
			end
			if (in_valid && !in_stall) begin
				predict_lookup(opcode, block_address, want);
				expected_lookups.push_back(want);
			end
		end
	end

	// watchdog on cycles without any handshake
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG_MAX) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic push_access(input logic op, input logic [ADDR_W-1:0] addr);
		pending_accesses.push_back('{op, addr});
	endtask

	// sampled mid-cycle so the driver's and monitor's updates have settled
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_accesses.size() != 0 || in_valid || expected_lookups.size() != 0);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_fill_limit(input logic [CFG_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		active_entries <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		fill_cfg = v;
	endtask

	// mostly addresses from a small pool so hits and evictions are common
	task automatic push_random(input int n, input int span);
		int k;
		int r;
		logic [ADDR_W-1:0] a;
		for (k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < 4)
				a = '0;
			else if (r < 78)
				a = addr_pool[$urandom_range(0, span)];
			else
				a = $urandom;
			push_access(logic'($urandom_range(0, 1)), a);
		end
	endtask

	task automatic run_phase(input logic [CFG_W-1:0] v, input int n, input int span);
		write_fill_limit(v);
		push_random(n, span);
		wait_drained();
	endtask

	initial begin : main
		int i;
		for (i = 0; i < ENTRIES; i++) begin
			tags[i] = '0;
			ranks[i] = 0;
		end
		addr_pool[0] = 32'hFFFF_FFFF;
		addr_pool[1] = 32'h0000_0001;
		addr_pool[2] = 32'h8000_0000;
		for (i = 3; i < POOL_SIZE; i++) begin
			addr_pool[i] = $urandom;
			if (addr_pool[i] == '0)
				addr_pool[i] = 32'h0000_0002;
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: zero address both ways, extremes, hits, fill to full, evictions
		push_access(OP_READ, 32'h0);
		push_access(OP_WRITE, 32'h0);
		push_access(OP_READ, 32'h0000_0001);
		push_access(OP_WRITE, 32'hFFFF_FFFF);
		push_access(OP_READ, 32'hFFFF_FFFF);
		push_access(OP_WRITE, 32'h0000_0001);
		push_access(OP_READ, 32'h8000_0000);
		push_access(OP_WRITE, 32'h7FFF_FFFF);
		for (i = 1; i <= 12; i++)
			push_access(logic'(i & 1), 32'h1000_0000 + i);
		push_access(OP_READ, 32'h0000_0001);
		push_access(OP_WRITE, 32'hAAAA_AAAA);
		push_access(OP_READ, 32'h5555_5555);
		wait_drained();

		// limit lowered below the fill count: all misses replace
		run_phase(CFG_W'(2), 250, 8);
		run_phase(CFG_W'(0), 150, 3);
		quiet <= 1'b1;
		run_phase(CFG_W'(31), 300, 20);
		quiet <= 1'b0;

		write_fill_limit(CFG_W'(5));
		push_random(300, 8);
		long_hold <= 1'b1;
		wait_drained();

		run_phase(CFG_W'(16), 300, 20);
		run_phase(CFG_W'(1), 150, 3);
		run_phase(CFG_W'(17), 300, 20);
		run_phase(CFG_W'(8), 250, 11);

		if (errors == 0 && expected_lookups.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

[filelist.f]
hdl/lbct_pkg.sv
hdl/lbct_cell.sv
hdl/lru_block_cache_tags_top.sv
verif/testbench.sv
